>>> rtl/core/sfr_pkg.sv
// shared types and constants for the framed receiver with crc-16 check
package sfr_pkg;

    localparam int PAYLOAD_DEPTH_DEF = 64;
    localparam int HEADER_BYTES      = 9;
    localparam int SYNC_BYTES        = 4;
    localparam int BYTE_INDEX_W      = 6;
    localparam int LEN_W             = 7;
    localparam int GAP_W             = 16;
    localparam int CFG_INDEX_W       = 3;
    localparam int CFG_DATA_W        = 16;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'h0000;

    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_0        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_1        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_2        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_3        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PAYLOAD   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_TICKS = 3'd5;

    localparam logic [7:0]       SYNC_RESET          = 8'd0;
    localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET   = 7'd64;
    localparam logic [GAP_W-1:0] TIMEOUT_TICKS_RESET = 16'd1000;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [7:0]              source_addr;
        logic [7:0]              dest_addr;
        logic [7:0]              transaction_id;
        logic [7:0]              command;
        logic [LEN_W-1:0]        payload_length;
        logic [BYTE_INDEX_W-1:0] byte_index;
        logic [7:0]              payload_byte;
        logic                    last;
    } result_t;

    typedef struct packed {
        logic [7:0]       sync_byte_0;
        logic [7:0]       sync_byte_1;
        logic [7:0]       sync_byte_2;
        logic [7:0]       sync_byte_3;
        logic [LEN_W-1:0] max_payload;
        logic [GAP_W-1:0] timeout_ticks;
    } cfg_t;

    // one accepted frame waiting for readout
    typedef struct packed {
        logic [7:0]       source_addr;
        logic [7:0]       dest_addr;
        logic [7:0]       transaction_id;
        logic [7:0]       command;
        logic [LEN_W-1:0] payload_length;
        logic             bank;
    } desc_t;

    typedef struct packed {
        logic valid;
        logic bank;
    } release_t;

endpackage

>>> rtl/core/sfr_ram.sv
// generic single-write, single-read ram with registered read data
module sfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/sfr_front.sv
// frame parser: sync hunt, header capture, payload write, crc check
module sfr_front
    import sfr_pkg::*;
#(
    parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF,
    localparam int IDX_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  cfg_t           cfg,
    input  logic           push,
    output logic           full,
    input  item_t          item,
    output logic           ram_wr_en,
    output logic [IDX_W:0] ram_wr_addr,
    output logic [7:0]     ram_wr_data,
    output logic           desc_push,
    output desc_t          desc,
    input  release_t       release_bank
);

    localparam logic [LEN_W-1:0] POS_LEN   = LEN_W'(HEADER_BYTES - 1);
    localparam logic [LEN_W-1:0] POS_HDR   = LEN_W'(HEADER_BYTES);
    localparam logic [LEN_W-1:0] POS_FIRST = LEN_W'(SYNC_BYTES);
    localparam logic [7:0]       DEPTH_B   = 8'(PAYLOAD_DEPTH);

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    logic [LEN_W-1:0] pos_reg, pos_next;
    logic [7:0]       src_reg, src_next;
    logic [7:0]       dst_reg, dst_next;
    logic [7:0]       tid_reg, tid_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       crc_lo_reg, crc_lo_next;
    logic [GAP_W-1:0] gap_reg, gap_next;
    logic             wbank_reg, wbank_next;
    logic [1:0]       busy_reg, busy_next;

    logic             accept;
    logic [7:0]       b;
    logic [7:0]       want;
    logic [LEN_W-1:0] crc_pos;
    logic [15:0]      crc_step;

    assign full     = busy_reg[wbank_reg];
    assign accept   = push && !full;
    assign b        = item.data_byte;
    assign crc_pos  = POS_HDR + len_reg;
    assign crc_step = crc_update((pos_reg == '0) ? CRC_INIT : crc_reg, b);

    always_comb
    begin
        unique case (pos_reg[1:0])
            2'd0:    want = cfg.sync_byte_0;
            2'd1:    want = cfg.sync_byte_1;
            2'd2:    want = cfg.sync_byte_2;
            default: want = cfg.sync_byte_3;
        endcase
    end

    assign ram_wr_addr = {wbank_reg, IDX_W'(pos_reg - POS_HDR)};
    assign ram_wr_data = b;

    assign desc.source_addr    = src_reg;
    assign desc.dest_addr      = dst_reg;
    assign desc.transaction_id = tid_reg;
    assign desc.command        = cmd_reg;
    assign desc.payload_length = len_reg;
    assign desc.bank           = wbank_reg;

    always_comb
    begin
        pos_next    = pos_reg;
        src_next    = src_reg;
        dst_next    = dst_reg;
        tid_next    = tid_reg;
        cmd_next    = cmd_reg;
        len_next    = len_reg;
        crc_next    = crc_reg;
        crc_lo_next = crc_lo_reg;
        gap_next    = gap_reg;
        wbank_next  = wbank_reg;
        busy_next   = busy_reg;
        ram_wr_en   = 1'b0;
        desc_push   = 1'b0;

        if (release_bank.valid)
        begin
            busy_next[release_bank.bank] = 1'b0;
        end

        if (accept)
        begin
            if (item.kind == KIND_TICK)
            begin
                if (pos_reg != '0)
                begin
                    if (gap_reg >= cfg.timeout_ticks)
                    begin
                        pos_next = '0;
                        gap_next = '0;
                    end
                    else
                    begin
                        gap_next = gap_reg + 1'b1;
                    end
                end
            end
            else
            begin
                gap_next = '0;
                if (pos_reg < POS_FIRST)
                begin
                    if (b != want)
                    begin
                        pos_next = '0;
                    end
                    else
                    begin
                        crc_next = crc_step;
                        pos_next = pos_reg + 1'b1;
                    end
                end
                else if (pos_reg < POS_HDR)
                begin
                    if (pos_reg == POS_LEN &&
                        (b == 8'd0 || b > {1'b0, cfg.max_payload} || b > DEPTH_B))
                    begin
                        pos_next = '0;
                    end
                    else
                    begin
                        case (pos_reg - POS_FIRST)
                            7'd0:    src_next = b;
                            7'd1:    dst_next = b;
                            7'd2:    tid_next = b;
                            7'd3:    cmd_next = b;
                            default: len_next = b[LEN_W-1:0];
                        endcase
                        crc_next = crc_step;
                        pos_next = pos_reg + 1'b1;
                    end
                end
                else if (pos_reg < crc_pos)
                begin
                    ram_wr_en = 1'b1;
                    crc_next  = crc_step;
                    pos_next  = pos_reg + 1'b1;
                end
                else if (pos_reg == crc_pos)
                begin
                    crc_lo_next = b;
                    pos_next    = pos_reg + 1'b1;
                end
                else
                begin
                    // high crc byte closes the frame either way
                    pos_next = '0;
                    if ({b, crc_lo_reg} == crc_reg)
                    begin
                        desc_push            = 1'b1;
                        busy_next[wbank_reg] = 1'b1;
                        wbank_next           = !wbank_reg;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            src_reg    <= '0;
            dst_reg    <= '0;
            tid_reg    <= '0;
            cmd_reg    <= '0;
            len_reg    <= '0;
            crc_reg    <= CRC_INIT;
            crc_lo_reg <= '0;
            gap_reg    <= '0;
            wbank_reg  <= 1'b0;
            busy_reg   <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            src_reg    <= src_next;
            dst_reg    <= dst_next;
            tid_reg    <= tid_next;
            cmd_reg    <= cmd_next;
            len_reg    <= len_next;
            crc_reg    <= crc_next;
            crc_lo_reg <= crc_lo_next;
            gap_reg    <= gap_next;
            wbank_reg  <= wbank_next;
            busy_reg   <= busy_next;
        end
    end

endmodule

>>> rtl/core/sfr_desc_fifo.sv
// two-entry queue of accepted frame descriptors between parser and readout
module sfr_desc_fifo
    import sfr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t din,
    input  logic  pop,
    output desc_t dout,
    output logic  empty
);

    // never more than one descriptor per payload bank
    desc_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign empty = (count_reg == 2'd0);
    assign dout  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop && !empty);
        end
    end

endmodule

>>> rtl/core/sfr_back.sv
// payload readout: walks one stored frame and presents one word per byte
module sfr_back
    import sfr_pkg::*;
#(
    parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF,
    localparam int IDX_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           desc_empty,
    input  desc_t          desc,
    output logic           desc_pop,
    output logic           ram_rd_en,
    output logic [IDX_W:0] ram_rd_addr,
    input  logic [7:0]     ram_rd_data,
    output release_t       release_bank,
    output logic           empty,
    input  logic           pop,
    output result_t        result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_HOLD
    } state_t;

    state_t           state_reg, state_next;
    desc_t            desc_reg, desc_next;
    logic [IDX_W-1:0] k_reg, k_next;
    result_t          out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    logic slot_free;
    logic is_last;

    assign slot_free   = !out_valid_reg || pop;
    assign is_last     = (LEN_W'(k_reg) + 1'b1) == desc_reg.payload_length;
    assign ram_rd_en   = (state_reg == S_READ);
    assign ram_rd_addr = {desc_reg.bank, k_reg};
    assign empty       = !out_valid_reg;
    assign result      = out_reg;

    always_comb
    begin
        state_next         = state_reg;
        desc_next          = desc_reg;
        k_next             = k_reg;
        out_next           = out_reg;
        out_valid_next     = out_valid_reg && !pop;
        desc_pop           = 1'b0;
        release_bank.valid = 1'b0;
        release_bank.bank  = desc_reg.bank;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!desc_empty)
                begin
                    desc_pop   = 1'b1;
                    desc_next  = desc;
                    k_next     = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_HOLD;
            end
            S_HOLD:
            begin
                if (slot_free)
                begin
                    out_next.source_addr    = desc_reg.source_addr;
                    out_next.dest_addr      = desc_reg.dest_addr;
                    out_next.transaction_id = desc_reg.transaction_id;
                    out_next.command        = desc_reg.command;
                    out_next.payload_length = desc_reg.payload_length;
                    out_next.byte_index     = BYTE_INDEX_W'(k_reg);
                    out_next.payload_byte   = ram_rd_data;
                    out_next.last           = is_last;
                    out_valid_next          = 1'b1;
                    if (is_last)
                    begin
                        // bank contents are all read, parser may reuse it
                        release_bank.valid = 1'b1;
                        state_next         = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        desc_reg <= desc_next;
        out_reg  <= out_next;
    end

endmodule

>>> rtl/core/sync_frame_receiver_crc16_core.sv
// top level of the framed receiver: configuration registers and block wiring
//
// Words are received bytes or time ticks. The parser takes one word per clock
// while full is low; it hunts for the four sync bytes, captures the header,
// writes the payload into one of two ram banks and checks the crc-16/xmodem
// sent low byte first. A good frame is handed to the readout side, which
// delivers one result word per payload byte, each word taking a ram read
// then an output register load. full rises only while both payload banks
// hold frames still waiting to be read out. Rejected frames produce nothing.
// The ram needs no clearing after reset.
module sync_frame_receiver_crc16_core
    import sfr_pkg::*;
#(
    parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   push,
    output logic                   full,
    input  item_t                  item,
    output logic                   empty,
    input  logic                   pop,
    output result_t                result
);

    localparam int IDX_W     = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
    localparam int RAM_DEPTH = 2 << IDX_W;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_byte_0   <= SYNC_RESET;
            cfg_reg.sync_byte_1   <= SYNC_RESET;
            cfg_reg.sync_byte_2   <= SYNC_RESET;
            cfg_reg.sync_byte_3   <= SYNC_RESET;
            cfg_reg.max_payload   <= MAX_PAYLOAD_RESET;
            cfg_reg.timeout_ticks <= TIMEOUT_TICKS_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                CFG_SYNC_0:        cfg_reg.sync_byte_0   <= cfg_data[7:0];
                CFG_SYNC_1:        cfg_reg.sync_byte_1   <= cfg_data[7:0];
                CFG_SYNC_2:        cfg_reg.sync_byte_2   <= cfg_data[7:0];
                CFG_SYNC_3:        cfg_reg.sync_byte_3   <= cfg_data[7:0];
                CFG_MAX_PAYLOAD:   cfg_reg.max_payload   <= cfg_data[LEN_W-1:0];
                CFG_TIMEOUT_TICKS: cfg_reg.timeout_ticks <= cfg_data[GAP_W-1:0];
                default:           ;
            endcase
        end
    end

    logic           ram_wr_en;
    logic [IDX_W:0] ram_wr_addr;
    logic [7:0]     ram_wr_data;
    logic           ram_rd_en;
    logic [IDX_W:0] ram_rd_addr;
    logic [7:0]     ram_rd_data;
    logic           desc_push;
    desc_t          desc_in;
    logic           desc_pop;
    desc_t          desc_out;
    logic           desc_empty;
    release_t       release_bank;

    sfr_front #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .push         (push),
        .full         (full),
        .item         (item),
        .ram_wr_en    (ram_wr_en),
        .ram_wr_addr  (ram_wr_addr),
        .ram_wr_data  (ram_wr_data),
        .desc_push    (desc_push),
        .desc         (desc_in),
        .release_bank (release_bank)
    );

    sfr_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_payload_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    sfr_desc_fifo u_desc_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (desc_push),
        .din   (desc_in),
        .pop   (desc_pop),
        .dout  (desc_out),
        .empty (desc_empty)
    );

    sfr_back #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .desc_empty   (desc_empty),
        .desc         (desc_out),
        .desc_pop     (desc_pop),
        .ram_rd_en    (ram_rd_en),
        .ram_rd_addr  (ram_rd_addr),
        .ram_rd_data  (ram_rd_data),
        .release_bank (release_bank),
        .empty        (empty),
        .pop          (pop),
        .result       (result)
    );

endmodule
